/* rtl/hcb_pkg.sv */
package hcb_pkg;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [15:0] frequency;
        logic        final_symbol;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_symbol;
        logic [5:0]  code_length;
        logic [15:0] code_bits;
        logic        too_long;
        logic [31:0] weighted_length;
        logic        end_of_codes;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PUSH_CHK, S_PUSH_RS, S_PUSH_RW,
        S_BUILD,
        S_POP0, S_POP1, S_POP2, S_POP3,
        S_SD_CHK, S_SD_RL, S_SD_WL, S_SD_RR, S_SD_WR, S_SD_DEC,
        S_POP_DONE, S_POP_W,
        S_ROOT, S_ROOT2,
        S_DC_CHK, S_DC_RD, S_DC_WR2,
        S_WP, S_WP_RD, S_WP_MUL, S_WP_ACC,
        S_OUT_RD, S_OUT
    } t_state;

endpackage

/* rtl/hcb_ram.sv */
module hcb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

/* rtl/huffman_code_builder.sv */
// Huffman code builder. Symbol/frequency beats are loaded with start while busy
// is low; each load, while fewer than MAX_SYMBOLS leaves are held, pushes the
// leaf into a min-heap held in a synchronous slot memory. The beat flagged
// final_symbol starts the build: pairs of nodes are popped and their parent
// pushed back, each pop sinking through the heap, after which the tree is
// walked from the root, the weighted path length is summed and one result is
// strobed on o_valid per leaf in load order. The receiver cannot stall: every
// result is valid for exactly one cycle and must be captured then. busy rises
// with the accepted load and stays high until the last result of the set is on
// the ports; it is already low in that final cycle, so the first beat of the
// next set may be taken then.
module huffman_code_builder #(
    parameter int MAX_SYMBOLS   = 64,
    parameter int MAX_CODE_BITS = 16,
    parameter int FREQ_BITS     = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  hcb_pkg::t_in  i_item,
    output logic          o_valid,
    output hcb_pkg::t_out o_result
);
    import hcb_pkg::*;

    localparam int SB  = $clog2(MAX_SYMBOLS);
    localparam int NB  = SB + 1;
    localparam int CB  = $clog2(MAX_SYMBOLS + 1);
    localparam int WB  = FREQ_BITS + 6;
    localparam int CW  = MAX_CODE_BITS;
    localparam int DW  = 6;
    localparam int DCW = DW + CW;

    // Memory ports.
    logic            slot_we, wt_we, ch_we, sym_we, dc_we;
    logic [SB-1:0]   slot_wa, slot_ra, ch_wa, ch_ra, sym_wa, sym_ra;
    logic [NB-1:0]   slot_wd, wt_wa, wt_ra, dc_wa, dc_ra;
    logic [NB-1:0]   slot_rd;
    logic [WB-1:0]   wt_wd, wt_rd;
    logic [2*NB-1:0] ch_wd, ch_rd;
    logic [7:0]      sym_rd;
    logic [DCW-1:0]  dc_wd, dc_rd;

    hcb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(NB)) u_slot (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_wa), .i_wdata(slot_wd),
        .i_raddr(slot_ra), .o_rdata(slot_rd));
    hcb_ram #(.DEPTH(2*MAX_SYMBOLS), .WIDTH(WB)) u_wt (
        .i_clk(i_clk), .i_we(wt_we), .i_waddr(wt_wa), .i_wdata(wt_wd),
        .i_raddr(wt_ra), .o_rdata(wt_rd));
    hcb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(2*NB)) u_ch (
        .i_clk(i_clk), .i_we(ch_we), .i_waddr(ch_wa), .i_wdata(ch_wd),
        .i_raddr(ch_ra), .o_rdata(ch_rd));
    hcb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(8)) u_sym (
        .i_clk(i_clk), .i_we(sym_we), .i_waddr(sym_wa), .i_wdata(i_item.symbol),
        .i_raddr(sym_ra), .o_rdata(sym_rd));
    hcb_ram #(.DEPTH(2*MAX_SYMBOLS), .WIDTH(DCW)) u_dc (
        .i_clk(i_clk), .i_we(dc_we), .i_waddr(dc_wa), .i_wdata(dc_wd),
        .i_raddr(dc_ra), .o_rdata(dc_rd));

    t_state        r_state, n_state;
    logic [CB-1:0] r_hc, n_hc, r_leaves, n_leaves, r_i, n_i;
    logic [NB-1:0] r_nc, n_nc, r_node, n_node, r_taken, n_taken, r_a, n_a;
    logic [NB-1:0] r_lnode, n_lnode, r_rnode, n_rnode, r_p, n_p;
    logic [NB-1:0] r_rc, n_rc;
    logic [SB-1:0] r_pos, n_pos, r_cur, n_cur;
    logic [WB-1:0] r_wm, n_wm, r_wa, n_wa, r_wl, n_wl, r_wr, n_wr;
    logic          r_phase, n_phase, r_build, n_build, r_final, n_final;
    logic          r_rvld, n_rvld, r_vld, n_vld;
    logic [DW-1:0] r_pd, n_pd;
    logic [CW-1:0] r_pc, n_pc;
    logic [31:0]   r_acc, n_acc, r_prod, n_prod;
    t_out          r_out, n_out;

    // Leaf weight: only the low FREQ_BITS bits of the frequency count.
    logic [WB+15:0] freq_ext;
    logic [WB-1:0]  freq_m;
    assign freq_ext = {{WB{1'b0}}, i_item.frequency};
    always_comb begin
        for (int b = 0; b < WB; b++) begin
            freq_m[b] = (b < FREQ_BITS) ? freq_ext[b] : 1'b0;
        end
    end

    logic [WB+31:0] wt_ext;
    logic [CW+15:0] code_ext;
    logic [SB:0]    l_idx, r_idx;
    logic [SB:0]    hc_ext;
    logic [SB-1:0]  up_idx;
    logic [DW-1:0]  dc_d;
    logic [CW-1:0]  dc_c;
    logic [DW-1:0]  child_d;
    logic [CW-1:0]  child_c0, child_c1;

    assign wt_ext   = {32'b0, wt_rd};
    assign dc_d     = dc_rd[DCW-1:CW];
    assign dc_c     = dc_rd[CW-1:0];
    assign code_ext = {16'b0, dc_c};
    assign l_idx    = {r_cur, 1'b1};
    assign r_idx    = (SB+1)'(l_idx + 1'b1);
    assign hc_ext   = (SB+1)'(r_hc);
    assign up_idx   = SB'((r_pos - 1'b1) >> 1);
    // Codes keep only their first MAX_CODE_BITS bits as the tree deepens.
    assign child_d  = DW'(dc_d + 1'b1);
    assign child_c0 = (dc_d < DW'(MAX_CODE_BITS)) ? {dc_c[CW-2:0], 1'b0} : dc_c;
    assign child_c1 = (dc_d < DW'(MAX_CODE_BITS)) ? {dc_c[CW-2:0], 1'b1} : dc_c;

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_vld;
    assign o_result = r_out;

    always_comb begin
        logic [WB-1:0] wmin;
        logic [NB-1:0] mnode;
        logic          moved;
        wmin = '0;
        mnode = '0;
        moved = 1'b0;
        n_state = r_state; n_hc = r_hc; n_leaves = r_leaves; n_i = r_i;
        n_nc = r_nc; n_node = r_node; n_taken = r_taken; n_a = r_a;
        n_lnode = r_lnode; n_rnode = r_rnode; n_p = r_p; n_rc = r_rc;
        n_pos = r_pos; n_cur = r_cur; n_wm = r_wm; n_wa = r_wa; n_wl = r_wl;
        n_wr = r_wr; n_phase = r_phase; n_build = r_build; n_final = r_final;
        n_rvld = r_rvld; n_pd = r_pd; n_pc = r_pc; n_acc = r_acc; n_prod = r_prod;
        n_out = r_out; n_vld = 1'b0;
        slot_we = 1'b0; slot_wa = '0; slot_wd = '0; slot_ra = '0;
        wt_we = 1'b0; wt_wa = '0; wt_wd = '0; wt_ra = '0;
        ch_we = 1'b0; ch_wa = '0; ch_wd = '0; ch_ra = '0;
        sym_we = 1'b0; sym_wa = '0; sym_ra = '0;
        dc_we = 1'b0; dc_wa = '0; dc_wd = '0; dc_ra = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_final = i_item.final_symbol;
                    n_build = 1'b0;
                    n_phase = 1'b0;
                    if (r_nc < NB'(MAX_SYMBOLS)) begin
                        sym_we = 1'b1;
                        sym_wa = r_nc[SB-1:0];
                        wt_we = 1'b1;
                        wt_wa = r_nc;
                        wt_wd = freq_m;
                        n_node = r_nc;
                        n_wm = freq_m;
                        n_pos = r_hc[SB-1:0];
                        n_hc = CB'(r_hc + 1'b1);
                        n_nc = NB'(r_nc + 1'b1);
                        n_state = S_PUSH_CHK;
                    end else if (i_item.final_symbol) begin
                        n_leaves = CB'(r_nc);
                        n_state = S_BUILD;
                    end
                end
            end
            // Sift-up: the climbing node and its weight stay in registers.
            S_PUSH_CHK: begin
                if (r_pos == '0) begin
                    slot_we = 1'b1;
                    slot_wa = '0;
                    slot_wd = r_node;
                    if (r_build) begin
                        n_state = S_BUILD;
                    end else if (r_final) begin
                        n_leaves = CB'(r_nc);
                        n_build = 1'b1;
                        n_state = S_BUILD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    slot_ra = up_idx;
                    n_state = S_PUSH_RS;
                end
            end
            S_PUSH_RS: begin
                n_lnode = slot_rd;
                wt_ra = slot_rd;
                n_state = S_PUSH_RW;
            end
            S_PUSH_RW: begin
                slot_we = 1'b1;
                slot_wa = r_pos;
                if (r_wm < wt_rd) begin
                    slot_wd = r_lnode;
                    n_pos = up_idx;
                    n_state = S_PUSH_CHK;
                end else begin
                    slot_wd = r_node;
                    if (r_build) begin
                        n_state = S_BUILD;
                    end else if (r_final) begin
                        n_leaves = CB'(r_nc);
                        n_build = 1'b1;
                        n_state = S_BUILD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_BUILD: begin
                n_build = 1'b1;
                n_state = (r_hc >= CB'(2)) ? S_POP0 : S_ROOT;
            end
            S_POP0: begin
                n_hc = CB'(r_hc - 1'b1);
                slot_ra = '0;
                n_state = S_POP1;
            end
            S_POP1: begin
                n_taken = slot_rd;
                slot_ra = r_hc[SB-1:0];
                n_state = S_POP2;
            end
            S_POP2: begin
                n_node = slot_rd;
                wt_ra = slot_rd;
                n_state = S_POP3;
            end
            S_POP3: begin
                n_wm = wt_rd;
                n_cur = '0;
                n_state = S_SD_CHK;
            end
            // Sift-down: the sinking node is written only where it settles.
            S_SD_CHK: begin
                if (l_idx >= hc_ext) begin
                    slot_we = 1'b1;
                    slot_wa = r_cur;
                    slot_wd = r_node;
                    n_state = S_POP_DONE;
                end else begin
                    slot_ra = l_idx[SB-1:0];
                    n_state = S_SD_RL;
                end
            end
            S_SD_RL: begin
                n_lnode = slot_rd;
                wt_ra = slot_rd;
                n_state = S_SD_WL;
            end
            S_SD_WL: begin
                n_wl = wt_rd;
                if (r_idx < hc_ext) begin
                    n_rvld = 1'b1;
                    slot_ra = r_idx[SB-1:0];
                    n_state = S_SD_RR;
                end else begin
                    n_rvld = 1'b0;
                    n_state = S_SD_DEC;
                end
            end
            S_SD_RR: begin
                n_rnode = slot_rd;
                wt_ra = slot_rd;
                n_state = S_SD_WR;
            end
            S_SD_WR: begin
                n_wr = wt_rd;
                n_state = S_SD_DEC;
            end
            S_SD_DEC: begin
                // Ties go to the child, and the right child after the left.
                wmin = r_wm;
                if (r_wm >= r_wl) begin
                    wmin = r_wl;
                    mnode = r_lnode;
                    moved = 1'b1;
                    n_cur = l_idx[SB-1:0];
                end
                if (r_rvld && (wmin >= r_wr)) begin
                    mnode = r_rnode;
                    moved = 1'b1;
                    n_cur = r_idx[SB-1:0];
                end
                slot_we = 1'b1;
                slot_wa = r_cur;
                if (moved) begin
                    slot_wd = mnode;
                    n_state = S_SD_CHK;
                end else begin
                    slot_wd = r_node;
                    n_state = S_POP_DONE;
                end
            end
            S_POP_DONE: begin
                wt_ra = r_taken;
                n_state = S_POP_W;
            end
            S_POP_W: begin
                if (!r_phase) begin
                    n_a = r_taken;
                    n_wa = wt_rd;
                    n_phase = 1'b1;
                    n_state = S_POP0;
                end else begin
                    ch_we = 1'b1;
                    ch_wa = SB'(r_nc - NB'(r_leaves));
                    ch_wd = {r_a, r_taken};
                    wt_we = 1'b1;
                    wt_wa = r_nc;
                    wt_wd = WB'(r_wa + wt_rd);
                    n_node = r_nc;
                    n_wm = WB'(r_wa + wt_rd);
                    n_pos = r_hc[SB-1:0];
                    n_hc = CB'(r_hc + 1'b1);
                    n_nc = NB'(r_nc + 1'b1);
                    n_phase = 1'b0;
                    n_state = S_PUSH_CHK;
                end
            end
            S_ROOT: begin
                slot_ra = '0;
                n_state = S_ROOT2;
            end
            S_ROOT2: begin
                dc_we = 1'b1;
                dc_wa = slot_rd;
                dc_wd = '0;
                n_p = NB'(r_nc - 1'b1);
                n_state = S_DC_CHK;
            end
            // Parents are visited newest first, so each is placed before its children.
            S_DC_CHK: begin
                if (r_p < NB'(r_leaves)) begin
                    n_state = S_WP;
                end else begin
                    ch_ra = SB'(r_p - NB'(r_leaves));
                    dc_ra = r_p;
                    n_state = S_DC_RD;
                end
            end
            S_DC_RD: begin
                n_rc = ch_rd[NB-1:0];
                n_pd = child_d;
                n_pc = child_c1;
                dc_we = 1'b1;
                dc_wa = ch_rd[2*NB-1:NB];
                dc_wd = {child_d, child_c0};
                n_state = S_DC_WR2;
            end
            S_DC_WR2: begin
                dc_we = 1'b1;
                dc_wa = r_rc;
                dc_wd = {r_pd, r_pc};
                n_p = NB'(r_p - 1'b1);
                n_state = S_DC_CHK;
            end
            S_WP: begin
                n_i = '0;
                n_acc = '0;
                n_state = S_WP_RD;
            end
            S_WP_RD: begin
                dc_ra = NB'(r_i);
                wt_ra = NB'(r_i);
                n_state = S_WP_MUL;
            end
            S_WP_MUL: begin
                n_prod = 32'(wt_ext[31:0] * 32'(dc_d));
                n_state = S_WP_ACC;
            end
            S_WP_ACC: begin
                n_acc = r_acc + r_prod;
                if (CB'(r_i + 1'b1) == r_leaves) begin
                    n_i = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_i = CB'(r_i + 1'b1);
                    n_state = S_WP_RD;
                end
            end
            S_OUT_RD: begin
                dc_ra = NB'(r_i);
                sym_ra = r_i[SB-1:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                n_vld = 1'b1;
                n_out.out_symbol = sym_rd;
                n_out.code_length = dc_d;
                n_out.code_bits = code_ext[15:0];
                n_out.too_long = (dc_d > DW'(MAX_CODE_BITS));
                n_out.weighted_length = r_acc;
                n_out.end_of_codes = (CB'(r_i + 1'b1) == r_leaves);
                n_i = CB'(r_i + 1'b1);
                if (CB'(r_i + 1'b1) == r_leaves) begin
                    n_hc = '0;
                    n_nc = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_OUT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hc <= '0;
            r_nc <= '0;
            r_vld <= 1'b0;
            r_phase <= 1'b0;
            r_build <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hc <= n_hc;
            r_nc <= n_nc;
            r_vld <= n_vld;
            r_phase <= n_phase;
            r_build <= n_build;
            r_final <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_leaves <= n_leaves; r_i <= n_i; r_node <= n_node; r_taken <= n_taken;
        r_a <= n_a; r_lnode <= n_lnode; r_rnode <= n_rnode; r_p <= n_p;
        r_rc <= n_rc; r_pos <= n_pos; r_cur <= n_cur;
        r_wm <= n_wm; r_wa <= n_wa; r_wl <= n_wl; r_wr <= n_wr;
        r_rvld <= n_rvld; r_pd <= n_pd; r_pc <= n_pc; r_acc <= n_acc;
        r_prod <= n_prod; r_out <= n_out;
    end
endmodule

/* rtl/hcb_checker.sv */
module hcb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input hcb_pkg::t_out o_result
);
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.end_of_codes |-> busy) else $error("result beat while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("load beat did not raise busy");

    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result beats back to back");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.end_of_codes |-> !busy) else $error("busy with last beat");

    a_wpl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.end_of_codes |=> ##1 (o_valid &&
        o_result.weighted_length == $past(o_result.weighted_length, 2)))
        else $error("weighted length changed within a set");
endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_result(o_result));

/* bench/tb_top.sv */
`timescale 1ns / 100ps

// Bench for the Huffman code builder. Sets of symbol/frequency beats are fed in
// with start/busy. Each accepted beat also runs through a behavioural copy of
// the min-heap construction held here, and the codes that this predicts are
// queued. The results strobed on o_valid are then compared, field by field,
// against the oldest queued code.
module tb_top;

    import hcb_pkg::*;

    localparam int NSYM     = 64;
    localparam int CODE_MAX = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_item = '0;
    logic o_valid;
    t_out o_result;

    huffman_code_builder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: node weights, the heap of node indexes, the children of
    // each internal node and the symbol of each leaf in load order.
    longint unsigned node_wt[0:2*NSYM-1];
    int              heap_of[0:NSYM-1];
    int              heap_fill;
    int              nodes_made;
    logic [7:0]      leaf_sym[0:NSYM-1];
    int              left_kid[0:NSYM-1];
    int              right_kid[0:NSYM-1];

    t_out expected_codes[$];
    int   errors = 0;
    int   beats_sent = 0;
    int   codes_seen = 0;
    int   sets_built = 0;
    int   idle_pct = 0;

    function automatic void swap_heap(int a, int b);
        int t;
        t = heap_of[a];
        heap_of[a] = heap_of[b];
        heap_of[b] = t;
    endfunction

    // Sift-up moves a node only while it is strictly lighter than its parent.
    function automatic void heap_insert(int node);
        int pos;
        int up;
        if (heap_fill >= NSYM) begin
            return;
        end
        pos = heap_fill;
        heap_of[pos] = node;
        heap_fill++;
        while (pos > 0) begin
            up = (pos - 1) / 2;
            if (node_wt[heap_of[pos]] < node_wt[heap_of[up]]) begin
                swap_heap(pos, up);
            end
            pos = up;
        end
    endfunction

    // Sift-down: a child not heavier than the current minimum takes over, the
    // left one checked first, so on equal children the right one wins.
    function automatic int heap_take_min();
        int cur;
        int l;
        int r;
        int m;
        int taken;
        cur = 0;
        heap_fill--;
        swap_heap(0, heap_fill);
        taken = heap_of[heap_fill];
        forever begin
            l = 2 * cur + 1;
            r = 2 * cur + 2;
            m = cur;
            if (l < heap_fill && !(node_wt[heap_of[m]] < node_wt[heap_of[l]])) begin
                m = l;
            end
            if (r < heap_fill && !(node_wt[heap_of[m]] < node_wt[heap_of[r]])) begin
                m = r;
            end
            if (m == cur) begin
                break;
            end
            swap_heap(cur, m);
            cur = m;
        end
        return taken;
    endfunction

    // Loads one leaf and, on the final beat of a set, builds the tree and
    // queues one code per leaf in load order.
    function automatic void load_leaf(t_in it);
        int              leaves;
        int              a;
        int              b;
        int              k;
        int              p;
        int              root;
        int              depth[0:2*NSYM-1];
        longint unsigned code[0:2*NSYM-1];
        logic [31:0]     wpl;
        longint unsigned bits;
        t_out            r;
        if (nodes_made < NSYM) begin
            leaf_sym[nodes_made] = it.symbol;
            node_wt[nodes_made] = it.frequency;
            heap_insert(nodes_made);
            nodes_made++;
        end
        if (!it.final_symbol) begin
            return;
        end
        leaves = nodes_made;
        while (heap_fill >= 2) begin
            a = heap_take_min();
            b = heap_take_min();
            k = nodes_made;
            left_kid[k - leaves] = a;
            right_kid[k - leaves] = b;
            node_wt[k] = node_wt[a] + node_wt[b];
            heap_insert(k);
            nodes_made++;
        end
        root = heap_of[0];
        for (k = 0; k < 2 * NSYM; k++) begin
            depth[k] = 0;
            code[k] = 0;
        end
        depth[root] = 0;
        // Parents are always made after their children, so walking down from
        // the newest node gives every child its parent's prefix in time.
        for (k = nodes_made; k > leaves; k--) begin
            p = k - 1;
            depth[left_kid[p - leaves]] = depth[p] + 1;
            code[left_kid[p - leaves]] = code[p] << 1;
            depth[right_kid[p - leaves]] = depth[p] + 1;
            code[right_kid[p - leaves]] = (code[p] << 1) | 64'd1;
        end
        wpl = '0;
        for (k = 0; k < leaves; k++) begin
            wpl += 32'(node_wt[k] * longint'(depth[k]));
        end
        for (k = 0; k < leaves; k++) begin
            bits = code[k];
            r.too_long = 1'b0;
            if (depth[k] > CODE_MAX) begin
                r.too_long = 1'b1;
                bits = bits >> (depth[k] - CODE_MAX);
            end
            r.out_symbol = leaf_sym[k];
            r.code_length = 6'(depth[k]);
            r.code_bits = bits[15:0];
            r.weighted_length = wpl;
            r.end_of_codes = (k + 1 == leaves);
            expected_codes.push_back(r);
        end
        heap_fill = 0;
        nodes_made = 0;
        sets_built++;
    endfunction

    // Sends one beat. It is entered and left just after a rising edge; start
    // stays high on return so that back-to-back beats need no second write.
    task automatic send_leaf(logic [7:0] s, logic [15:0] f, logic fin);
        t_in it;
        it.symbol = s;
        it.frequency = f;
        it.final_symbol = fin;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        // busy only moves on a rising edge, so the falling edge is a safe
        // place to see whether the next edge will take the beat.
        forever begin
            @(negedge i_clk);
            if (!busy) begin
                break;
            end
        end
        @(posedge i_clk);
        load_leaf(it);
        beats_sent++;
    endtask

    // Holds off until every queued code has come back.
    task automatic drain_codes();
        start <= 1'b0;
        while (expected_codes.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic report_field(string name, longint unsigned exp_v, longint unsigned act_v);
        $display("%0t ns: mismatch in %s, expected %0h, got %0h", $time, name, exp_v, act_v);
        errors++;
    endtask

    // Results are held for one cycle from a rising edge, so they are taken at
    // the falling edge in the middle of that cycle.
    always @(negedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid) begin
            codes_seen++;
            if (expected_codes.size() == 0) begin
                $display("%0t ns: code beat with nothing expected, got %p", $time, o_result);
                errors++;
            end else begin
                e = expected_codes.pop_front();
                if (o_result.out_symbol !== e.out_symbol)
                    report_field("out_symbol", e.out_symbol, o_result.out_symbol);
                if (o_result.code_length !== e.code_length)
                    report_field("code_length", e.code_length, o_result.code_length);
                if (o_result.code_bits !== e.code_bits)
                    report_field("code_bits", e.code_bits, o_result.code_bits);
                if (o_result.too_long !== e.too_long)
                    report_field("too_long", e.too_long, o_result.too_long);
                if (o_result.weighted_length !== e.weighted_length)
                    report_field("weighted_length", e.weighted_length,
                                 o_result.weighted_length);
                if (o_result.end_of_codes !== e.end_of_codes)
                    report_field("end_of_codes", e.end_of_codes, o_result.end_of_codes);
            end
        end
    end

    // A lone symbol gets an empty code.
    task automatic test_single_symbol();
        send_leaf(8'hA5, 16'h1234, 1'b1);
        drain_codes();
    endtask

    // Field extremes: symbols 0 and 255, zero and full-scale weights, and a
    // set of equal weights that exercises every tie rule in the heap.
    task automatic test_extremes_and_ties();
        send_leaf(8'h00, 16'h0000, 1'b0);
        send_leaf(8'hFF, 16'hFFFF, 1'b1);
        send_leaf(8'h00, 16'hFFFF, 1'b0);
        send_leaf(8'hFF, 16'hFFFF, 1'b0);
        send_leaf(8'h55, 16'h0000, 1'b1);
        for (int i = 0; i < 5; i++) begin
            send_leaf(8'(8'h10 + i), 16'h0007, i == 4);
        end
        drain_codes();
    endtask

    // Fibonacci weights give a chain-shaped tree, so the deepest codes run
    // past the code width and come back flagged and cut short.
    task automatic test_long_codes();
        int a;
        int b;
        int c;
        a = 1;
        b = 1;
        for (int i = 0; i < 20; i++) begin
            send_leaf(8'(i * 13), 16'(a), i == 19);
            c = a + b;
            a = b;
            b = c;
        end
        drain_codes();
    endtask

    // A full set plus one more: the extra beat is dropped, but being final it
    // still starts the build of the set already loaded.
    task automatic test_set_overflow();
        for (int i = 0; i <= NSYM; i++) begin
            send_leaf(8'($urandom), 16'($urandom), i == NSYM);
        end
        drain_codes();
    endtask

    // Random sets, mostly small, with the occasional larger one, cut to fit
    // the number of beats asked for.
    task automatic test_random_sets(int n_beats);
        int sent;
        int size;
        sent = 0;
        while (sent < n_beats) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
            if (size > n_beats - sent) begin
                size = n_beats - sent;
            end
            for (int i = 0; i < size; i++) begin
                send_leaf(8'($urandom),
                          ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom),
                          i == size - 1);
            end
            sent += size;
        end
    endtask

    initial begin
        heap_fill = 0;
        nodes_made = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_symbol();
        test_extremes_and_ties();
        test_long_codes();
        test_set_overflow();

        idle_pct = 37;
        test_random_sets(6);
        idle_pct = 51;
        test_random_sets(6);
        idle_pct = 0;
        test_random_sets(6);

        drain_codes();
        repeat (200) @(posedge i_clk);

        $display("Covered %0d beats in %0d sets, %0d codes checked, including single,",
                 beats_sent, sets_built, codes_seen);
        $display("tied, overlong and overflowing sets under three idle patterns.");
        if (errors == 0 && expected_codes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
